// ===== hw/rtl/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaler blit package
// Shared widths, register map, status codes, stage types and color helpers
// of the nearest-neighbor scaled-blit pixel engine.
// ----------------------------------------------------------------------------
package nns_pkg;

   localparam int CRD_W       = 16;
   localparam int DIV_STAGES  = CRD_W;
   localparam int SRC_OFF_W   = 34;
   localparam int DST_OFF_W   = 35;
   localparam int COLOR_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_CLIPPED = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;
   localparam logic [1:0] STAT_FORMAT  = 2'd3;

   localparam logic MODE_MAP     = 1'b0;
   localparam logic MODE_CONVERT = 1'b1;

   localparam logic [2:0] REG_SRC_SIZE   = 3'd0;
   localparam logic [2:0] REG_SRC_BPP    = 3'd1;
   localparam logic [2:0] REG_DST_ORIGIN = 3'd2;
   localparam logic [2:0] REG_DST_SIZE   = 3'd3;
   localparam logic [2:0] REG_SCREEN     = 3'd4;
   localparam logic [2:0] REG_FB_LAYOUT  = 3'd5;

   localparam logic [7:0] SRC_BPP_RESET = 8'd2;
   localparam logic [7:0] BPP_RGB565    = 8'd2;
   localparam logic [7:0] BPP_RGB888    = 8'd3;
   localparam logic [7:0] BPP_XRGB      = 8'd4;

   typedef struct packed {
      logic [31:0] num_x;
      logic [31:0] num_y;
      logic [15:0] den_x;
      logic [15:0] den_y;
   } div_in_type;

   typedef struct packed {
      logic [15:0] quo_x;
      logic [15:0] quo_y;
   } div_out_type;

   typedef struct packed {
      logic        valid;
      logic        mode;
      logic [1:0]  status;
      logic [15:0] scr_x;
      logic [15:0] scr_y;
      logic [23:0] rgb;
   } side_type;

   // Expands a 5-bit channel to 8 bits as floor(x * 255 / 31), reciprocal form.
   function automatic logic [7:0] expand5(input logic [4:0] x);
      logic [12:0] n;
      logic [28:0] p;
      n = {x, 8'd0} - {8'd0, x};
      p = 29'(n) * 29'd33826;
      return p[27:20];
   endfunction

   // Expands a 6-bit channel to 8 bits as floor(x * 255 / 63), reciprocal form.
   function automatic logic [7:0] expand6(input logic [5:0] x);
      logic [13:0] n;
      logic [28:0] p;
      n = {x, 8'd0} - {8'd0, x};
      p = 29'(n) * 29'd16645;
      return p[27:20];
   endfunction

   // Places one 8-bit channel into the framebuffer word.
   function automatic logic [15:0] pack_channel(input logic [7:0] v, input logic [7:0] desc);
      logic [3:0]  sz;
      logic [7:0]  t;
      logic [23:0] w;
      sz = (desc[3:0] > 4'd8) ? 4'd8 : desc[3:0];
      t  = v >> (4'd8 - sz);
      w  = {16'd0, t} << desc[7:4];
      return w[15:0];
   endfunction

endpackage

// ===== hw/rtl/nns_div.sv =====
// ----------------------------------------------------------------------------
// Scaler blit divider
// Pipelined restoring divider for both axes, one quotient bit per stage.
// The dividend must be below the divisor times 2**16.
// ----------------------------------------------------------------------------
module nns_div (
   input  logic                clock,
   input  logic                en,
   input  nns_pkg::div_in_type div_in,
   output nns_pkg::div_out_type div_out
);

   typedef struct packed {
      logic [15:0] rem;
      logic [15:0] low;
      logic [15:0] den;
      logic [15:0] quo;
   } lane_type;

   function automatic lane_type div_step(input lane_type l);
      lane_type   r;
      logic [16:0] acc;
      logic [16:0] diff;
      logic        ge;
      acc   = {l.rem, l.low[15]};
      diff  = acc - {1'b0, l.den};
      ge    = (acc >= {1'b0, l.den});
      r.rem = ge ? diff[15:0] : acc[15:0];
      r.low = {l.low[14:0], 1'b0};
      r.den = l.den;
      r.quo = {l.quo[14:0], ge};
      return r;
   endfunction

   lane_type x_ff [nns_pkg::DIV_STAGES];
   lane_type y_ff [nns_pkg::DIV_STAGES];
   lane_type x_in [nns_pkg::DIV_STAGES];
   lane_type y_in [nns_pkg::DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < nns_pkg::DIV_STAGES; k++) begin : g_stage
         if (k == 0) begin : g_first
            always_comb begin
               x_in[k] = div_step('{rem: div_in.num_x[31:16], low: div_in.num_x[15:0],
                                    den: div_in.den_x, quo: 16'd0});
               y_in[k] = div_step('{rem: div_in.num_y[31:16], low: div_in.num_y[15:0],
                                    den: div_in.den_y, quo: 16'd0});
            end
         end else begin : g_next
            always_comb begin
               x_in[k] = div_step(x_ff[k-1]);
               y_in[k] = div_step(y_ff[k-1]);
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[k] <= x_in[k];
               y_ff[k] <= y_in[k];
            end
         end
      end
   endgenerate

   assign div_out.quo_x = x_ff[nns_pkg::DIV_STAGES-1].quo;
   assign div_out.quo_y = y_ff[nns_pkg::DIV_STAGES-1].quo;

endmodule

// ===== hw/rtl/nearest_neighbor_scaler_blit.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor scaled-blit pixel engine
// Maps target coordinates to source and framebuffer byte offsets, and
// converts source pixel words to the 16-bit framebuffer color layout.
// ----------------------------------------------------------------------------
// The engine takes one request transfer per clock while the response side is
// not stalled, and returns one response transfer per request, in order. The
// source coordinates come from the 16-stage pipelined divider, one quotient
// bit per stage. A stall on the response side freezes the whole pipeline, so
// request ready is low only while a valid response waits. The user must write
// registers only while the engine is idle; the block does not enforce this.
module nearest_neighbor_scaler_blit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] target_col, [31:16] target_row, [63:32] src_pixel
   input  logic [nns_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [33:0] src_offset, [68:34] dst_offset, [84:69] fb_color, [87:85] zero
   output logic [nns_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [nns_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nns_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nns_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nns_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int LAST = nns_pkg::DIV_STAGES;

   logic [31:0] src_size_ff;
   logic [7:0]  src_bpp_ff;
   logic [31:0] dst_origin_ff;
   logic [31:0] dst_size_ff;
   logic [31:0] screen_ff;
   logic [23:0] fb_layout_ff;
   logic [23:0] pitch_ff;
   logic [23:0] pitch_in;
   logic [2:0]  csr_index;
   logic        csr_write;

   logic        en;

   logic        in_valid_ff;
   logic        in_mode_ff;
   logic [15:0] in_col_ff;
   logic [15:0] in_row_ff;
   logic [31:0] in_pix_ff;

   nns_pkg::side_type   side_ff [LAST+1];
   nns_pkg::side_type   side_in;
   nns_pkg::div_in_type div_in_ff;
   nns_pkg::div_in_type div_in_in;
   nns_pkg::div_out_type div_out;

   logic        m1_valid_ff;
   logic        m1_mode_ff;
   logic [1:0]  m1_status_ff;
   logic [15:0] m1_scr_x_ff;
   logic [33:0] m1_row_ff;
   logic [23:0] m1_col_ff;
   logic [31:0] m1_scr_ff;
   logic [15:0] m1_color_ff;
   logic [33:0] m1_row_in;
   logic [23:0] m1_col_in;
   logic [31:0] m1_scr_in;
   logic [15:0] m1_color_in;

   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic [33:0] out_src_ff;
   logic [34:0] out_dst_ff;
   logic [15:0] out_color_ff;
   logic [33:0] out_src_in;
   logic [34:0] out_dst_in;
   logic [15:0] out_color_in;
   logic [32:0] dst_sum;
   logic        out_ok;

   logic [15:0] sw, sh, dw, dh, xres, yres;
   logic        fmt_ok;
   logic [15:0] scr_x, scr_y;
   logic [7:0]  red, green, blue;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_size_ff   <= '0;
         src_bpp_ff    <= nns_pkg::SRC_BPP_RESET;
         dst_origin_ff <= '0;
         dst_size_ff   <= '0;
         screen_ff     <= '0;
         fb_layout_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            nns_pkg::REG_SRC_SIZE:   src_size_ff   <= csr_pwdata;
            nns_pkg::REG_SRC_BPP:    src_bpp_ff    <= csr_pwdata[7:0];
            nns_pkg::REG_DST_ORIGIN: dst_origin_ff <= csr_pwdata;
            nns_pkg::REG_DST_SIZE:   dst_size_ff   <= csr_pwdata;
            nns_pkg::REG_SCREEN:     screen_ff     <= csr_pwdata;
            nns_pkg::REG_FB_LAYOUT:  fb_layout_ff  <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         nns_pkg::REG_SRC_SIZE:   csr_prdata = src_size_ff;
         nns_pkg::REG_SRC_BPP:    csr_prdata = {24'd0, src_bpp_ff};
         nns_pkg::REG_DST_ORIGIN: csr_prdata = dst_origin_ff;
         nns_pkg::REG_DST_SIZE:   csr_prdata = dst_size_ff;
         nns_pkg::REG_SCREEN:     csr_prdata = screen_ff;
         nns_pkg::REG_FB_LAYOUT:  csr_prdata = {8'd0, fb_layout_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   assign pitch_in = src_size_ff[15:0] * src_bpp_ff;

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
   end

   // The whole pipeline moves together whenever the output can advance.
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_mode_ff <= req_tuser;
         in_col_ff  <= req_tdata[15:0];
         in_row_ff  <= req_tdata[31:16];
         in_pix_ff  <= req_tdata[63:32];
      end
   end

   // Check stage: status, screen position, numerators and channel expansion.
   assign sw     = src_size_ff[15:0];
   assign sh     = src_size_ff[31:16];
   assign dw     = dst_size_ff[15:0];
   assign dh     = dst_size_ff[31:16];
   assign xres   = screen_ff[15:0];
   assign yres   = screen_ff[31:16];
   assign fmt_ok = (src_bpp_ff == nns_pkg::BPP_RGB565) ||
                   (src_bpp_ff == nns_pkg::BPP_RGB888) ||
                   (src_bpp_ff == nns_pkg::BPP_XRGB);
   assign scr_x  = dst_origin_ff[15:0] + in_col_ff;
   assign scr_y  = dst_origin_ff[31:16] + in_row_ff;

   always_comb begin
      unique case (src_bpp_ff)
         nns_pkg::BPP_RGB565: begin
            red   = nns_pkg::expand5(in_pix_ff[15:11]);
            green = nns_pkg::expand6(in_pix_ff[10:5]);
            blue  = nns_pkg::expand5(in_pix_ff[4:0]);
         end
         nns_pkg::BPP_XRGB: begin
            red   = in_pix_ff[23:16];
            green = in_pix_ff[15:8];
            blue  = in_pix_ff[7:0];
         end
         nns_pkg::BPP_RGB888: begin
            red   = in_pix_ff[7:0];
            green = in_pix_ff[15:8];
            blue  = in_pix_ff[23:16];
         end
         default: begin
            red   = 8'd0;
            green = 8'd0;
            blue  = 8'd0;
         end
      endcase
   end

   always_comb begin
      side_in.valid = in_valid_ff;
      side_in.mode  = in_mode_ff;
      side_in.scr_x = scr_x;
      side_in.scr_y = scr_y;
      side_in.rgb   = {blue, green, red};
      if (in_mode_ff == nns_pkg::MODE_MAP) begin
         priority if (sw == 16'd0 || sh == 16'd0 || dw == 16'd0 || dh == 16'd0 ||
                      src_bpp_ff == 8'd0) begin
            side_in.status = nns_pkg::STAT_INVALID;
         end else if (in_col_ff >= dw || in_row_ff >= dh) begin
            side_in.status = nns_pkg::STAT_CLIPPED;
         end else if (scr_y >= yres || scr_x >= xres) begin
            side_in.status = nns_pkg::STAT_CLIPPED;
         end else if (!fmt_ok) begin
            side_in.status = nns_pkg::STAT_FORMAT;
         end else begin
            side_in.status = nns_pkg::STAT_OK;
         end
      end else begin
         side_in.status = fmt_ok ? nns_pkg::STAT_OK : nns_pkg::STAT_FORMAT;
      end
      div_in_in.num_x = in_col_ff * sw;
      div_in_in.num_y = in_row_ff * sh;
      div_in_in.den_x = dw;
      div_in_in.den_y = dh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (en) begin
         side_ff[0].valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].mode   <= side_in.mode;
         side_ff[0].status <= side_in.status;
         side_ff[0].scr_x  <= side_in.scr_x;
         side_ff[0].scr_y  <= side_in.scr_y;
         side_ff[0].rgb    <= side_in.rgb;
         div_in_ff         <= div_in_in;
      end
   end

   // Divider stages, with the side data traveling alongside.
   nns_div u_div (
      .clock   (clock),
      .en      (en),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   genvar k;
   generate
      for (k = 1; k <= LAST; k++) begin : g_side
         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[k].valid <= 1'b0;
            end else if (en) begin
               side_ff[k].valid <= side_ff[k-1].valid;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k].mode   <= side_ff[k-1].mode;
               side_ff[k].status <= side_ff[k-1].status;
               side_ff[k].scr_x  <= side_ff[k-1].scr_x;
               side_ff[k].scr_y  <= side_ff[k-1].scr_y;
               side_ff[k].rgb    <= side_ff[k-1].rgb;
            end
         end
      end
   endgenerate

   // Product stage.
   assign m1_row_in   = div_out.quo_y * pitch_ff;
   assign m1_col_in   = div_out.quo_x * src_bpp_ff;
   assign m1_scr_in   = side_ff[LAST].scr_y * xres;
   assign m1_color_in = nns_pkg::pack_channel(side_ff[LAST].rgb[7:0], fb_layout_ff[7:0]) |
                        nns_pkg::pack_channel(side_ff[LAST].rgb[15:8], fb_layout_ff[15:8]) |
                        nns_pkg::pack_channel(side_ff[LAST].rgb[23:16], fb_layout_ff[23:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= side_ff[LAST].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_mode_ff   <= side_ff[LAST].mode;
         m1_status_ff <= side_ff[LAST].status;
         m1_scr_x_ff  <= side_ff[LAST].scr_x;
         m1_row_ff    <= m1_row_in;
         m1_col_ff    <= m1_col_in;
         m1_scr_ff    <= m1_scr_in;
         m1_color_ff  <= m1_color_in;
      end
   end

   // Output stage.
   assign out_ok       = (m1_status_ff == nns_pkg::STAT_OK);
   assign dst_sum      = {1'b0, m1_scr_ff} + {17'd0, m1_scr_x_ff};
   assign out_src_in   = (out_ok && m1_mode_ff == nns_pkg::MODE_MAP) ?
                         (m1_row_ff + {10'd0, m1_col_ff}) : 34'd0;
   assign out_dst_in   = (out_ok && m1_mode_ff == nns_pkg::MODE_MAP) ?
                         {1'b0, dst_sum, 1'b0} : 35'd0;
   assign out_color_in = (out_ok && m1_mode_ff == nns_pkg::MODE_CONVERT) ?
                         m1_color_ff : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_status_ff <= m1_status_ff;
         out_src_ff    <= out_src_in;
         out_dst_ff    <= out_dst_in;
         out_color_ff  <= out_color_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {3'd0, out_color_ff, out_dst_ff, out_src_ff};

endmodule

// ===== hw/rtl/nns_checker.sv =====
// ----------------------------------------------------------------------------
// Scaler blit checker
// Port-level checks of the scaled-blit pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module nns_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [nns_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [nns_pkg::STATUS_W-1:0]       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Response changed while stalled.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nns_pkg::STAT_OK |-> rsp_tdata[84:0] == '0)
      else $error("Failed transfer carries nonzero payload.");

   a_color_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[84:69] != '0 |-> rsp_tdata[68:0] == '0)
      else $error("Color and offsets in the same transfer.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Request accepted while the response is stalled.");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid right after reset.");

endmodule

bind nearest_neighbor_scaler_blit nns_checker u_nns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Scaler blit testbench
// Drives target coordinates and source pixel words into the scaled-blit engine
// and compares every response against an in-bench model of the offset mapping
// and color packing, or a directed item's own result. The run covers register
// settings from extreme to typical and idles both sides at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FB_BYTES_PER_PIXEL = 2;
   localparam int PHASES             = 10;
   localparam int PHASE_ITEMS        = 125;

   typedef struct packed {
      logic [1:0]  status;
      logic [33:0] src_off;
      logic [34:0] dst_off;
      logic [15:0] color;
   } blit_result_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [31:0]     reg_val;
      logic            mode;
      logic [15:0]     col;
      logic [15:0]     row;
      logic [31:0]     pix;
      bit              typed;
      blit_result_type want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [nns_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = nns_pkg::MODE_MAP;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [nns_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [nns_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [nns_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [nns_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [nns_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   logic [31:0]  cfg_src_size = '0;
   logic [7:0]   cfg_src_bpp = nns_pkg::SRC_BPP_RESET;
   logic [31:0]  cfg_dst_origin = '0;
   logic [31:0]  cfg_dst_size = '0;
   logic [31:0]  cfg_screen = '0;
   logic [23:0]  cfg_fb_layout = '0;

   logic            item_typed = 1'b0;
   blit_result_type item_want = '0;

   blit_result_type pending_results[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count = 0;
   bit              tx_gaps = 1'b0;
   bit              rx_stalls = 1'b0;
   int              stall_left = 0;

   nearest_neighbor_scaler_blit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [15:0] scaled_coord(input logic [15:0] t, input logic [15:0] s,
                                                input logic [15:0] d);
      logic [63:0] q;
      q = (64'(t) * 64'(s)) / 64'(d);
      if (q >= 64'(s))
         q = 64'(s) - 64'd1;
      return q[15:0];
   endfunction

   function automatic logic [15:0] fb_channel(input logic [7:0] v, input logic [7:0] desc);
      logic [3:0]  sz;
      logic [31:0] w;
      sz = (desc[3:0] > 4'd8) ? 4'd8 : desc[3:0];
      w  = (32'(v) >> (32'd8 - 32'(sz))) << desc[7:4];
      return w[15:0];
   endfunction

   function automatic blit_result_type blit_predict(input logic mode, input logic [15:0] tx,
                                                    input logic [15:0] ty,
                                                    input logic [31:0] pix);
      blit_result_type r;
      logic [15:0]     sw, sh, dw, dh, xres, yres, scr_x, scr_y, sx, sy;
      logic [63:0]     so, dof;
      logic [7:0]      bpp, red, grn, blu;
      bit              fmt_ok;
      r      = '0;
      bpp    = cfg_src_bpp;
      fmt_ok = (bpp == nns_pkg::BPP_RGB565) || (bpp == nns_pkg::BPP_RGB888) ||
               (bpp == nns_pkg::BPP_XRGB);
      if (mode == nns_pkg::MODE_MAP) begin
         sw    = cfg_src_size[15:0];
         sh    = cfg_src_size[31:16];
         dw    = cfg_dst_size[15:0];
         dh    = cfg_dst_size[31:16];
         xres  = cfg_screen[15:0];
         yres  = cfg_screen[31:16];
         scr_x = cfg_dst_origin[15:0] + tx;
         scr_y = cfg_dst_origin[31:16] + ty;
         if (sw == 0 || sh == 0 || dw == 0 || dh == 0 || bpp == 0) begin
            r.status = nns_pkg::STAT_INVALID;
         end else if (tx >= dw || ty >= dh || scr_y >= yres || scr_x >= xres) begin
            r.status = nns_pkg::STAT_CLIPPED;
         end else if (!fmt_ok) begin
            r.status = nns_pkg::STAT_FORMAT;
         end else begin
            sy = scaled_coord(ty, sh, dh);
            sx = scaled_coord(tx, sw, dw);
            so  = 64'(sy) * (64'(sw) * 64'(bpp)) + 64'(sx) * 64'(bpp);
            dof = (64'(scr_y) * 64'(xres) + 64'(scr_x)) * 64'(FB_BYTES_PER_PIXEL);
            r.status  = nns_pkg::STAT_OK;
            r.src_off = so[33:0];
            r.dst_off = dof[34:0];
         end
      end else begin
         red = '0;
         grn = '0;
         blu = '0;
         case (bpp)
            nns_pkg::BPP_RGB565: begin
               red = 8'((32'(pix[15:11]) * 255) / 31);
               grn = 8'((32'(pix[10:5]) * 255) / 63);
               blu = 8'((32'(pix[4:0]) * 255) / 31);
            end
            nns_pkg::BPP_XRGB: begin
               red = pix[23:16];
               grn = pix[15:8];
               blu = pix[7:0];
            end
            nns_pkg::BPP_RGB888: begin
               red = pix[7:0];
               grn = pix[15:8];
               blu = pix[23:16];
            end
            default: r.status = nns_pkg::STAT_FORMAT;
         endcase
         if (fmt_ok)
            r.color = fb_channel(red, cfg_fb_layout[7:0]) |
                      fb_channel(grn, cfg_fb_layout[15:8]) |
                      fb_channel(blu, cfg_fb_layout[23:16]);
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch in %s: got %0h, want %0h", what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      blit_result_type oldest;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("response with nothing pending", 64'(rsp_tuser), 64'd0);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_tuser !== oldest.status)
                  flag_mismatch("status", 64'(rsp_tuser), 64'(oldest.status));
               if (rsp_tdata[33:0] !== oldest.src_off)
                  flag_mismatch("src_offset", 64'(rsp_tdata[33:0]), 64'(oldest.src_off));
               if (rsp_tdata[68:34] !== oldest.dst_off)
                  flag_mismatch("dst_offset", 64'(rsp_tdata[68:34]), 64'(oldest.dst_off));
               if (rsp_tdata[84:69] !== oldest.color)
                  flag_mismatch("fb_color", 64'(rsp_tdata[84:69]), 64'(oldest.color));
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(item_typed ? item_want :
               blit_predict(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]));
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                    $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pixel_req(input logic mode, input logic [15:0] col,
                                 input logic [15:0] row, input logic [31:0] pix,
                                 input bit typed, input blit_result_type want);
      int gap;
      gap = 0;
      if (tx_gaps && $urandom_range(0, 99) < 25)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pix, row, col};
      req_tuser  <= mode;
      item_typed <= typed;
      item_want  <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] want_rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         nns_pkg::REG_SRC_SIZE: begin
            cfg_src_size = val;
            want_rd      = val;
         end
         nns_pkg::REG_SRC_BPP: begin
            cfg_src_bpp = val[7:0];
            want_rd     = {24'd0, val[7:0]};
         end
         nns_pkg::REG_DST_ORIGIN: begin
            cfg_dst_origin = val;
            want_rd        = val;
         end
         nns_pkg::REG_DST_SIZE: begin
            cfg_dst_size = val;
            want_rd      = val;
         end
         nns_pkg::REG_SCREEN: begin
            cfg_screen = val;
            want_rd    = val;
         end
         nns_pkg::REG_FB_LAYOUT: begin
            cfg_fb_layout = val[23:0];
            want_rd       = {8'd0, val[23:0]};
         end
         default: want_rd = '0;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want_rd)
         flag_mismatch("register read", 64'(csr_prdata), 64'(want_rd));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] val);
      stim_row_type s;
      s.kind    = ROW_CFG;
      s.reg_idx = idx;
      s.reg_val = val;
      s.mode    = nns_pkg::MODE_MAP;
      s.col     = '0;
      s.row     = '0;
      s.pix     = '0;
      s.typed   = 1'b0;
      s.want    = '0;
      directed_rows.push_back(s);
   endfunction

   function automatic void add_item(input logic mode, input logic [15:0] col,
                                    input logic [15:0] row, input logic [31:0] pix,
                                    input bit typed, input logic [1:0] status,
                                    input logic [33:0] src_off, input logic [34:0] dst_off,
                                    input logic [15:0] color);
      stim_row_type s;
      s.kind         = ROW_ITEM;
      s.reg_idx      = '0;
      s.reg_val      = '0;
      s.mode         = mode;
      s.col          = col;
      s.row          = row;
      s.pix          = pix;
      s.typed        = typed;
      s.want.status  = status;
      s.want.src_off = src_off;
      s.want.dst_off = dst_off;
      s.want.color   = color;
      directed_rows.push_back(s);
   endfunction

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(0, 19))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [15:0] pick_pos();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 31));
   endfunction

   function automatic logic [15:0] pick_res();
      case ($urandom_range(0, 9))
         0:       return 16'hFFFF;
         1:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(32, 1024));
      endcase
   endfunction

   task automatic random_setup();
      logic [7:0]  bpp;
      logic [23:0] layout;
      case ($urandom_range(0, 9))
         0, 1, 2: bpp = nns_pkg::BPP_RGB565;
         3, 4:    bpp = nns_pkg::BPP_RGB888;
         5, 6:    bpp = nns_pkg::BPP_XRGB;
         7:       bpp = 8'd0;
         8:       bpp = 8'($urandom_range(0, 255));
         default: bpp = 8'd1;
      endcase
      case ($urandom_range(0, 5))
         0:       layout = 24'h0556B5;
         1:       layout = 24'hFFFFFF;
         2:       layout = 24'h000000;
         default: layout = 24'($urandom);
      endcase
      program_reg(nns_pkg::REG_SRC_SIZE, {pick_dim(), pick_dim()});
      program_reg(nns_pkg::REG_SRC_BPP, {24'($urandom), bpp});
      program_reg(nns_pkg::REG_DST_ORIGIN, {pick_pos(), pick_pos()});
      program_reg(nns_pkg::REG_DST_SIZE, {pick_dim(), pick_dim()});
      program_reg(nns_pkg::REG_SCREEN, {pick_res(), pick_res()});
      program_reg(nns_pkg::REG_FB_LAYOUT, {8'($urandom), layout});
   endtask

   initial begin : stimulus
      logic [15:0] col, row, dw, dh;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_INVALID,
               '0, '0, '0);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h0000FFFF, 1, nns_pkg::STAT_OK,
               '0, '0, '0);
      add_cfg(nns_pkg::REG_FB_LAYOUT, 32'h000556B5);
      add_item(nns_pkg::MODE_CONVERT, 16'hFFFF, 16'hFFFF, 32'h0000FFFF, 1, nns_pkg::STAT_OK,
               '0, '0, 16'hFFFF);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00000000, 1, nns_pkg::STAT_OK,
               '0, '0, 16'h0000);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'hFFFF0000, 1, nns_pkg::STAT_OK,
               '0, '0, 16'h0000);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00001234, 0, '0, '0, '0, '0);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'(nns_pkg::BPP_XRGB));
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'hFFFFFFFF, 1, nns_pkg::STAT_OK,
               '0, '0, 16'hFFFF);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00FF0000, 1, nns_pkg::STAT_OK,
               '0, '0, 16'hF800);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'(nns_pkg::BPP_RGB888));
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h000000FF, 1, nns_pkg::STAT_OK,
               '0, '0, 16'hF800);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00FF0000, 1, nns_pkg::STAT_OK,
               '0, '0, 16'h001F);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'd0);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'hFFFFFFFF, 1, nns_pkg::STAT_FORMAT,
               '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_INVALID,
               '0, '0, '0);
      add_cfg(nns_pkg::REG_FB_LAYOUT, 32'hFFFFFFFF);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'(nns_pkg::BPP_XRGB));
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00010101, 1, nns_pkg::STAT_OK,
               '0, '0, 16'h8000);
      add_item(nns_pkg::MODE_CONVERT, 16'd0, 16'd0, 32'h00FEFEFE, 1, nns_pkg::STAT_OK,
               '0, '0, 16'h0000);
      add_cfg(nns_pkg::REG_SRC_SIZE, 32'h00030005);
      add_cfg(nns_pkg::REG_DST_SIZE, 32'h0006000A);
      add_cfg(nns_pkg::REG_SCREEN, 32'h01000140);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'(nns_pkg::BPP_RGB565));
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_OK, '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd9, 16'd5, 32'd0, 0, '0, '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd10, 16'd0, 32'd0, 1, nns_pkg::STAT_CLIPPED,
               '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd6, 32'd0, 1, nns_pkg::STAT_CLIPPED,
               '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1, nns_pkg::STAT_CLIPPED,
               '0, '0, '0);
      add_cfg(nns_pkg::REG_DST_ORIGIN, 32'hFFFFFFFF);
      add_item(nns_pkg::MODE_MAP, 16'd1, 16'd1, 32'd0, 0, '0, '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_CLIPPED,
               '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd1, 32'd0, 1, nns_pkg::STAT_CLIPPED,
               '0, '0, '0);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'd5);
      add_item(nns_pkg::MODE_MAP, 16'd1, 16'd1, 32'd0, 1, nns_pkg::STAT_FORMAT,
               '0, '0, '0);
      add_cfg(nns_pkg::REG_SRC_SIZE, 32'hFFFFFFFF);
      add_cfg(nns_pkg::REG_DST_SIZE, 32'hFFFFFFFF);
      add_cfg(nns_pkg::REG_SCREEN, 32'hFFFFFFFF);
      add_cfg(nns_pkg::REG_DST_ORIGIN, 32'h00000000);
      add_cfg(nns_pkg::REG_SRC_BPP, 32'(nns_pkg::BPP_XRGB));
      add_item(nns_pkg::MODE_MAP, 16'hFFFE, 16'hFFFE, 32'd0, 0, '0, '0, '0, '0);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_OK, '0, '0, '0);
      add_cfg(nns_pkg::REG_SRC_SIZE, 32'h00010000);
      add_item(nns_pkg::MODE_MAP, 16'd0, 16'd0, 32'd0, 1, nns_pkg::STAT_INVALID,
               '0, '0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            drain_results();
            program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_pixel_req(directed_rows[i].mode, directed_rows[i].col, directed_rows[i].row,
                           directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         random_setup();
         tx_gaps   = (ph != 0) && ($urandom_range(0, 3) != 0);
         rx_stalls = (ph != 0) && ($urandom_range(0, 3) != 0);
         dw = cfg_dst_size[15:0];
         dh = cfg_dst_size[31:16];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == PHASE_ITEMS / 2)
               drain_results();
            col = (dw != 0 && $urandom_range(0, 9) < 8) ? 16'($urandom_range(0, dw - 1)) :
                                                          16'($urandom_range(0, 65535));
            row = (dh != 0 && $urandom_range(0, 9) < 8) ? 16'($urandom_range(0, dh - 1)) :
                                                          16'($urandom_range(0, 65535));
            send_pixel_req(1'($urandom_range(0, 1)), col, row, $urandom, 1'b0, '0);
         end
      end

      drain_results();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/nns_pkg.sv
hw/rtl/nns_div.sv
hw/rtl/nearest_neighbor_scaler_blit.sv
hw/rtl/nns_checker.sv
bench/tb_top.sv
